@@ rtl/dco_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dco_pkg - shared constants for the diamond / circle overlap block
// Holds the field width for lengths and the vertex and edge tables of the
// diamond.
// ----------------------------------------------------------------------------
package dco_pkg;

   localparam int LEN_BITS   = 10;   // radius, half width, half height
   localparam int NUM_VERTS  = 4;
   localparam int NUM_EDGES  = 4;
   localparam int CROSS_BITS = 32;   // a cross product at or above 2^32 never hits
   localparam int PIPE_DEPTH = 6;    // register stages from request to response

   typedef logic [1:0] vert_idx_type;

   localparam vert_idx_type VTX_TOP    = 2'd0;
   localparam vert_idx_type VTX_BOTTOM = 2'd1;
   localparam vert_idx_type VTX_LEFT   = 2'd2;
   localparam vert_idx_type VTX_RIGHT  = 2'd3;

   // edges: top-right, bottom-right, bottom-left, top-left
   localparam vert_idx_type EDGE_FROM [NUM_EDGES] = '{VTX_TOP, VTX_BOTTOM, VTX_BOTTOM, VTX_TOP};
   localparam vert_idx_type EDGE_TO   [NUM_EDGES] = '{VTX_RIGHT, VTX_RIGHT, VTX_LEFT, VTX_LEFT};

endpackage

`default_nettype wire

@@ rtl/diamond_circle_overlap.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// diamond_circle_overlap - pipelined diamond versus circle hit test
// Reports a hit when a diamond vertex lies strictly inside the circle, or
// when the circle reaches the open interior of one of the diamond's edges.
//
//   channel   ports                          handshake
//   -------   ----------------------------   ---------------------------------
//   request   req_circle_*, req_diamond_*,   taken at an edge with start high
//             req_half_width/height          and busy low
//   response  rsp_hit                        rsp_valid high for one cycle
//
// Cycles: one request per cycle, sustained. Each response comes out of the
// six register stages in order: vertex offsets, products, sums and range
// checks, magnitude and r^2*|e|^2, cross squared, final compare.
// Reset: synchronous; empties the pipeline and holds busy high for the
// cycle after reset. No other state.
// Stalls: none. The receiver cannot hold responses off, so the pipeline
// advances every cycle and busy is low outside reset.
// ----------------------------------------------------------------------------
module diamond_circle_overlap
   import dco_pkg::*;
#(
   parameter int COORD_BITS = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [COORD_BITS-1:0] req_circle_x,
   input  logic signed [COORD_BITS-1:0] req_circle_y,
   input  logic        [LEN_BITS-1:0]   req_circle_radius,
   input  logic signed [COORD_BITS-1:0] req_diamond_x,
   input  logic signed [COORD_BITS-1:0] req_diamond_y,
   input  logic        [LEN_BITS-1:0]   req_half_width,
   input  logic        [LEN_BITS-1:0]   req_half_height,
   output logic                         rsp_valid,
   output logic                         rsp_hit
);

   // vertex coordinates need room for center plus a full length
   localparam int VB   = ((COORD_BITS > LEN_BITS + 1) ? COORD_BITS : LEN_BITS + 1) + 1;
   localparam int WB   = VB + 1;                  // vertex to center offsets
   localparam int EB   = LEN_BITS + 1;            // edge vector components
   localparam int SQB  = 2 * WB;                  // squared offsets
   localparam int MB   = EB + WB;                 // edge products
   localparam int PB   = MB + 1;                  // dot and cross sums
   localparam int EEB  = 2 * LEN_BITS + 1;        // |e|^2
   localparam int R2B  = 2 * LEN_BITS;            // r^2
   localparam int REB  = R2B + EEB;               // r^2 * |e|^2
   localparam int ACW  = (PB > CROSS_BITS + 1) ? PB : CROSS_BITS + 1;
   localparam int PRB  = 2 * CROSS_BITS;          // cross squared

   // ---------------------------------------------------------------- control
   logic                  accept;
   logic                  busy_ff;
   logic                  busy_in;
   logic [PIPE_DEPTH-1:0] vld_ff;
   logic [PIPE_DEPTH-1:0] vld_in;

   assign accept  = start && !busy_ff;
   assign busy_in = reset;
   assign vld_in  = {vld_ff[PIPE_DEPTH-2:0], accept};
   assign busy    = busy_ff;

   always_ff @(posedge clock) begin
      busy_ff <= busy_in;
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // ---------------------------------------------------------------- stage 1
   // Build the four vertices, their offsets to the center, and per edge the
   // edge vector e = B - A and w = C - A.
   logic signed [VB-1:0] cx, cy, dx, dy, hw, hh;
   logic signed [VB-1:0] vx [NUM_VERTS];
   logic signed [VB-1:0] vy [NUM_VERTS];
   logic signed [WB-1:0] s1_dx_in [NUM_VERTS];
   logic signed [WB-1:0] s1_dy_in [NUM_VERTS];
   logic signed [EB-1:0] s1_ex_in [NUM_EDGES];
   logic signed [EB-1:0] s1_ey_in [NUM_EDGES];
   logic signed [WB-1:0] s1_wx_in [NUM_EDGES];
   logic signed [WB-1:0] s1_wy_in [NUM_EDGES];

   always_comb begin
      cx = VB'(req_circle_x);
      cy = VB'(req_circle_y);
      dx = VB'(req_diamond_x);
      dy = VB'(req_diamond_y);
      hw = signed'(VB'(req_half_width));
      hh = signed'(VB'(req_half_height));

      vx[VTX_TOP]    = dx;
      vy[VTX_TOP]    = dy + hh;
      vx[VTX_BOTTOM] = dx;
      vy[VTX_BOTTOM] = dy - hh;
      vx[VTX_LEFT]   = dx - hw;
      vy[VTX_LEFT]   = dy;
      vx[VTX_RIGHT]  = dx + hw;
      vy[VTX_RIGHT]  = dy;

      for (int v = 0; v < NUM_VERTS; v++) begin
         s1_dx_in[v] = WB'(vx[v]) - WB'(cx);
         s1_dy_in[v] = WB'(vy[v]) - WB'(cy);
      end
      for (int e = 0; e < NUM_EDGES; e++) begin
         s1_ex_in[e] = EB'(vx[EDGE_TO[e]] - vx[EDGE_FROM[e]]);
         s1_ey_in[e] = EB'(vy[EDGE_TO[e]] - vy[EDGE_FROM[e]]);
         s1_wx_in[e] = WB'(cx) - WB'(vx[EDGE_FROM[e]]);
         s1_wy_in[e] = WB'(cy) - WB'(vy[EDGE_FROM[e]]);
      end
   end

   logic        [LEN_BITS-1:0] s1_r_ff, s1_hw_ff, s1_hh_ff;
   logic signed [WB-1:0]       s1_dx_ff [NUM_VERTS];
   logic signed [WB-1:0]       s1_dy_ff [NUM_VERTS];
   logic signed [EB-1:0]       s1_ex_ff [NUM_EDGES];
   logic signed [EB-1:0]       s1_ey_ff [NUM_EDGES];
   logic signed [WB-1:0]       s1_wx_ff [NUM_EDGES];
   logic signed [WB-1:0]       s1_wy_ff [NUM_EDGES];

   always_ff @(posedge clock) begin
      s1_r_ff  <= req_circle_radius;
      s1_hw_ff <= req_half_width;
      s1_hh_ff <= req_half_height;
      s1_dx_ff <= s1_dx_in;
      s1_dy_ff <= s1_dy_in;
      s1_ex_ff <= s1_ex_in;
      s1_ey_ff <= s1_ey_in;
      s1_wx_ff <= s1_wx_in;
      s1_wy_ff <= s1_wy_in;
   end

   // ---------------------------------------------------------------- stage 2
   // All first-level products, one multiplier each, registered.
   logic        [R2B-1:0]      s2_r2_ff;
   logic        [R2B-1:0]      s2_hw2_ff, s2_hh2_ff;
   logic signed [SQB-1:0]      s2_dxx_ff [NUM_VERTS];
   logic signed [SQB-1:0]      s2_dyy_ff [NUM_VERTS];
   logic signed [MB-1:0]       s2_exwx_ff [NUM_EDGES];
   logic signed [MB-1:0]       s2_eywy_ff [NUM_EDGES];
   logic signed [MB-1:0]       s2_exwy_ff [NUM_EDGES];
   logic signed [MB-1:0]       s2_eywx_ff [NUM_EDGES];

   always_ff @(posedge clock) begin
      s2_r2_ff  <= R2B'(s1_r_ff)  * R2B'(s1_r_ff);
      s2_hw2_ff <= R2B'(s1_hw_ff) * R2B'(s1_hw_ff);
      s2_hh2_ff <= R2B'(s1_hh_ff) * R2B'(s1_hh_ff);
      for (int v = 0; v < NUM_VERTS; v++) begin
         s2_dxx_ff[v] <= SQB'(s1_dx_ff[v]) * SQB'(s1_dx_ff[v]);
         s2_dyy_ff[v] <= SQB'(s1_dy_ff[v]) * SQB'(s1_dy_ff[v]);
      end
      for (int e = 0; e < NUM_EDGES; e++) begin
         s2_exwx_ff[e] <= MB'(s1_ex_ff[e]) * MB'(s1_wx_ff[e]);
         s2_eywy_ff[e] <= MB'(s1_ey_ff[e]) * MB'(s1_wy_ff[e]);
         s2_exwy_ff[e] <= MB'(s1_ex_ff[e]) * MB'(s1_wy_ff[e]);
         s2_eywx_ff[e] <= MB'(s1_ey_ff[e]) * MB'(s1_wx_ff[e]);
      end
   end

   // ---------------------------------------------------------------- stage 3
   // Vertex distance test, |e|^2, dot and cross sums, and the open-interval
   // check 0 < e.w < e.e (a degenerate edge fails it by itself).
   logic        [SQB:0]         dist2 [NUM_VERTS];
   logic signed [PB-1:0]        ew [NUM_EDGES];
   logic        [NUM_VERTS-1:0] s3_vhit_in;
   logic        [NUM_EDGES-1:0] s3_ok_in;
   logic        [EEB-1:0]       s3_ee_in;
   logic signed [PB-1:0]        s3_cr_in [NUM_EDGES];

   always_comb begin
      s3_ee_in = EEB'(s2_hw2_ff) + EEB'(s2_hh2_ff);
      for (int v = 0; v < NUM_VERTS; v++) begin
         dist2[v]      = (SQB + 1)'(unsigned'(s2_dxx_ff[v]))
                       + (SQB + 1)'(unsigned'(s2_dyy_ff[v]));
         s3_vhit_in[v] = dist2[v] < (SQB + 1)'(s2_r2_ff);
      end
      for (int e = 0; e < NUM_EDGES; e++) begin
         ew[e]       = PB'(s2_exwx_ff[e]) + PB'(s2_eywy_ff[e]);
         s3_cr_in[e] = PB'(s2_exwy_ff[e]) - PB'(s2_eywx_ff[e]);
         s3_ok_in[e] = (ew[e] > 0) && (ew[e] < signed'(PB'(s3_ee_in)));
      end
   end

   logic        [NUM_VERTS-1:0] s3_vhit_ff;
   logic        [NUM_EDGES-1:0] s3_ok_ff;
   logic        [EEB-1:0]       s3_ee_ff;
   logic        [R2B-1:0]       s3_r2_ff;
   logic signed [PB-1:0]        s3_cr_ff [NUM_EDGES];

   always_ff @(posedge clock) begin
      s3_vhit_ff <= s3_vhit_in;
      s3_ok_ff   <= s3_ok_in;
      s3_ee_ff   <= s3_ee_in;
      s3_r2_ff   <= s2_r2_ff;
      s3_cr_ff   <= s3_cr_in;
   end

   // ---------------------------------------------------------------- stage 4
   // Take |cross|, drop edges whose cross reaches 2^32, form r^2 * |e|^2.
   logic [PB-1:0]         cr_mag [NUM_EDGES];
   logic [ACW-1:0]        cr_wide [NUM_EDGES];
   logic [NUM_EDGES-1:0]  s4_en_in;
   logic [CROSS_BITS-1:0] s4_ac_in [NUM_EDGES];

   always_comb begin
      for (int e = 0; e < NUM_EDGES; e++) begin
         cr_mag[e]   = s3_cr_ff[e][PB-1] ? PB'(-s3_cr_ff[e]) : PB'(s3_cr_ff[e]);
         cr_wide[e]  = ACW'(cr_mag[e]);
         s4_ac_in[e] = cr_wide[e][CROSS_BITS-1:0];
         s4_en_in[e] = s3_ok_ff[e] && !(|cr_wide[e][ACW-1:CROSS_BITS]);
      end
   end

   logic                  s4_vany_ff;
   logic [NUM_EDGES-1:0]  s4_en_ff;
   logic [CROSS_BITS-1:0] s4_ac_ff [NUM_EDGES];
   logic [REB-1:0]        s4_re_ff;

   always_ff @(posedge clock) begin
      s4_vany_ff <= |s3_vhit_ff;
      s4_en_ff   <= s4_en_in;
      s4_ac_ff   <= s4_ac_in;
      s4_re_ff   <= REB'(s3_r2_ff) * REB'(s3_ee_ff);
   end

   // ---------------------------------------------------------------- stage 5
   // Square the cross magnitude.
   logic                 s5_vany_ff;
   logic [NUM_EDGES-1:0] s5_en_ff;
   logic [PRB-1:0]       s5_sq_ff [NUM_EDGES];
   logic [REB-1:0]       s5_re_ff;

   always_ff @(posedge clock) begin
      s5_vany_ff <= s4_vany_ff;
      s5_en_ff   <= s4_en_ff;
      s5_re_ff   <= s4_re_ff;
      for (int e = 0; e < NUM_EDGES; e++) begin
         s5_sq_ff[e] <= PRB'(s4_ac_ff[e]) * PRB'(s4_ac_ff[e]);
      end
   end

   // ---------------------------------------------------------------- stage 6
   // Compare cross^2 against r^2 * |e|^2 and merge with the vertex test.
   logic [NUM_EDGES-1:0] edge_hit;
   logic                 rsp_hit_in;
   logic                 rsp_hit_ff;

   always_comb begin
      for (int e = 0; e < NUM_EDGES; e++) begin
         edge_hit[e] = s5_en_ff[e] && (s5_sq_ff[e] <= PRB'(s5_re_ff));
      end
      rsp_hit_in = s5_vany_ff || (|edge_hit);
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff <= rsp_hit_in;
   end

   assign rsp_valid = vld_ff[PIPE_DEPTH-1];
   assign rsp_hit   = rsp_hit_ff;

   // ------------------------------------------------------------- assertions
   a_req_gets_rsp: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##6 rsp_valid)
      else $error("request taken without a response six cycles later");

   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 6))
      else $error("response without a matching request");

   a_busy_after_reset: assert property (@(posedge clock)
      reset |=> busy)
      else $error("busy low in the cycle after reset");

   a_zero_radius_no_vertex: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[1] && s2_r2_ff == '0) |=> (s3_vhit_ff == '0))
      else $error("vertex hit with zero radius");

   a_flat_edge_no_hit: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[2] && s3_ee_ff == '0) |-> (s3_ok_ff == '0))
      else $error("edge accepted on a degenerate diamond");

endmodule

`default_nettype wire

@@ test/dco_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// dco_tb_pkg - request record and hit scoreboard for the overlap bench
// Computes the expected hit of every accepted request with exact integer
// arithmetic and compares it against the responses in order.
// ----------------------------------------------------------------------------
package dco_tb_pkg;

   import dco_pkg::*;

   localparam int COORD_BITS = 12;

   typedef struct {
      logic signed [COORD_BITS-1:0] circle_x;
      logic signed [COORD_BITS-1:0] circle_y;
      logic        [LEN_BITS-1:0]   circle_radius;
      logic signed [COORD_BITS-1:0] diamond_x;
      logic signed [COORD_BITS-1:0] diamond_y;
      logic        [LEN_BITS-1:0]   half_width;
      logic        [LEN_BITS-1:0]   half_height;
   } overlap_query_t;

   class overlap_scoreboard;

      bit hit_queue[$];
      int errors;

      function new();
         errors = 0;
      endfunction

      // strictly inside: squared distance below r^2
      static function bit vertex_inside(longint vx, longint vy, longint cx, longint cy,
                                        longint r2);
         longint ox, oy;
         ox = vx - cx;
         oy = vy - cy;
         return (ox * ox + oy * oy) < r2;
      endfunction

      // projection in the open interior and line distance within r
      static function bit edge_reaches(longint ax, longint ay, longint bx, longint by,
                                       longint cx, longint cy, longint r2);
         longint ex, ey, wx, wy, ee, ew, cr;
         ex = bx - ax;
         ey = by - ay;
         wx = cx - ax;
         wy = cy - ay;
         ee = ex * ex + ey * ey;
         ew = ex * wx + ey * wy;
         cr = ex * wy - ey * wx;
         if (ew <= 0 || ew >= ee) return 1'b0;
         if (cr < 0) cr = -cr;
         return (cr * cr) <= (r2 * ee);
      endfunction

      static function bit overlap_hit(overlap_query_t q);
         longint cx, cy, dx, dy, hw, hh, r2;
         longint top_x, top_y, rgt_x, rgt_y, lft_x, lft_y, bot_x, bot_y;
         cx = longint'(q.circle_x);
         cy = longint'(q.circle_y);
         dx = longint'(q.diamond_x);
         dy = longint'(q.diamond_y);
         hw = longint'(q.half_width);
         hh = longint'(q.half_height);
         r2 = longint'(q.circle_radius) * longint'(q.circle_radius);
         top_x = dx;      top_y = dy + hh;
         rgt_x = dx + hw; rgt_y = dy;
         lft_x = dx - hw; lft_y = dy;
         bot_x = dx;      bot_y = dy - hh;
         return vertex_inside(top_x, top_y, cx, cy, r2) ||
                vertex_inside(bot_x, bot_y, cx, cy, r2) ||
                vertex_inside(lft_x, lft_y, cx, cy, r2) ||
                vertex_inside(rgt_x, rgt_y, cx, cy, r2) ||
                edge_reaches(top_x, top_y, rgt_x, rgt_y, cx, cy, r2) ||
                edge_reaches(bot_x, bot_y, rgt_x, rgt_y, cx, cy, r2) ||
                edge_reaches(bot_x, bot_y, lft_x, lft_y, cx, cy, r2) ||
                edge_reaches(top_x, top_y, lft_x, lft_y, cx, cy, r2);
      endfunction

      function void note_request(overlap_query_t q);
         hit_queue.push_back(overlap_hit(q));
      endfunction

      function void check_response(logic actual);
         bit want;
         if (hit_queue.size() == 0) begin
            errors++;
            $display("%0t: unexpected response: expected none, actual hit=%b", $time, actual);
            return;
         end
         want = hit_queue.pop_front();
         if (actual !== want) begin
            errors++;
            $display("%0t: hit mismatch: expected %b, actual %b", $time, want, actual);
         end
      endfunction

      function int pending();
         return hit_queue.size();
      endfunction

   endclass

endpackage

@@ test/diamond_circle_overlap_tb.sv @@
// ----------------------------------------------------------------------------
// diamond_circle_overlap_tb - self-checking bench for the overlap pipeline
// Drives directed corner requests and then 2000 random ones, with
// random idle gaps, and checks every response hit against a scoreboard that
// recomputes the vertex and edge tests in exact integer arithmetic.
// ----------------------------------------------------------------------------
module diamond_circle_overlap_tb;

   import dco_pkg::*;
   import dco_tb_pkg::*;

   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int RANDOM_REQUESTS = 2000;
   localparam int DRAIN_EVERY     = 500;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic signed [COORD_BITS-1:0] req_circle_x      = '0;
   logic signed [COORD_BITS-1:0] req_circle_y      = '0;
   logic        [LEN_BITS-1:0]   req_circle_radius = '0;
   logic signed [COORD_BITS-1:0] req_diamond_x     = '0;
   logic signed [COORD_BITS-1:0] req_diamond_y     = '0;
   logic        [LEN_BITS-1:0]   req_half_width    = '0;
   logic        [LEN_BITS-1:0]   req_half_height   = '0;
   logic rsp_valid;
   logic rsp_hit;

   overlap_scoreboard hit_board = new();

   int accepted_count = 0;   // requests taken so far, advanced at the rising edge
   int idle_cycles    = 0;   // cycles in a row with neither request nor response
   int burst_left     = 0;   // requests still to send back to back

   diamond_circle_overlap #(
      .COORD_BITS(COORD_BITS)
   ) uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_circle_x     (req_circle_x),
      .req_circle_y     (req_circle_y),
      .req_circle_radius(req_circle_radius),
      .req_diamond_x    (req_diamond_x),
      .req_diamond_y    (req_diamond_y),
      .req_half_width   (req_half_width),
      .req_half_height  (req_half_height),
      .rsp_valid        (rsp_valid),
      .rsp_hit          (rsp_hit)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Sample both channels at the rising edge: check the response first, then
   // note the request taken at this same edge. Also run the watchdog here.
   always @(posedge clock) begin : monitor
      overlap_query_t seen;
      bit active;
      active = 1'b0;
      if (!reset) begin
         if (rsp_valid === 1'b1) begin
            hit_board.check_response(rsp_hit);
            active = 1'b1;
         end
         if (start && !busy) begin
            seen.circle_x      = req_circle_x;
            seen.circle_y      = req_circle_y;
            seen.circle_radius = req_circle_radius;
            seen.diamond_x     = req_diamond_x;
            seen.diamond_y     = req_diamond_y;
            seen.half_width    = req_half_width;
            seen.half_height   = req_half_height;
            hit_board.note_request(seen);
            accepted_count++;
            active = 1'b1;
         end
         if (active) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** diamond_circle_overlap: FAILED **");
            $finish;
         end
      end
   end

   // Pack plain integers into a request; the field widths truncate them.
   function automatic overlap_query_t query_of(int cx, int cy, int r, int dx, int dy,
                                               int hw, int hh);
      overlap_query_t q;
      q.circle_x      = cx[COORD_BITS-1:0];
      q.circle_y      = cy[COORD_BITS-1:0];
      q.circle_radius = r[LEN_BITS-1:0];
      q.diamond_x     = dx[COORD_BITS-1:0];
      q.diamond_y     = dy[COORD_BITS-1:0];
      q.half_width    = hw[LEN_BITS-1:0];
      q.half_height   = hh[LEN_BITS-1:0];
      return q;
   endfunction

   // Mostly short lengths so shapes stay local, with the full range now and then.
   function automatic int pick_length();
      if ($urandom_range(0, 99) < 80) return int'($urandom_range(0, 63));
      return int'($urandom_range(0, 1023));
   endfunction

   function automatic int pick_coord();
      return int'($urandom_range(0, 4095)) - 2048;
   endfunction

   // Build one random request. Most land near the diamond so both outcomes
   // show up often; some put the center exactly on an edge, some collapse the
   // diamond to a segment or a point, and the rest are uniform over the fields.
   function automatic overlap_query_t random_query();
      int kind, cx, cy, r, dx, dy, hw, hh, span, k, a, b, j, step_x, step_y, from_y;
      bit from_top;
      kind = $urandom_range(0, 99);
      dx   = pick_coord();
      dy   = pick_coord();
      hw   = pick_length();
      hh   = pick_length();
      r    = pick_length();
      if (kind < 25) begin
         cx = pick_coord();
         cy = pick_coord();
         r  = int'($urandom_range(0, 1023));
         hw = int'($urandom_range(0, 1023));
         hh = int'($urandom_range(0, 1023));
      end else if (kind < 70) begin
         span = hw + hh + r + 4;
         cx   = dx + int'($urandom_range(0, 2 * span)) - span;
         cy   = dy + int'($urandom_range(0, 2 * span)) - span;
      end else if (kind < 90) begin
         // walk integer points along one edge, then nudge a little at times
         k        = $urandom_range(1, 20);
         a        = $urandom_range(0, 20);
         b        = $urandom_range(0, 20);
         hw       = a * k;
         hh       = b * k;
         from_top = $urandom_range(0, 1);
         from_y   = from_top ? hh : -hh;
         step_x   = $urandom_range(0, 1) ? a : -a;
         step_y   = from_top ? -b : b;
         j        = $urandom_range(0, k);
         cx       = dx + j * step_x;
         cy       = dy + from_y + j * step_y;
         if ($urandom_range(0, 1)) begin
            cx = cx + int'($urandom_range(0, 4)) - 2;
            cy = cy + int'($urandom_range(0, 4)) - 2;
         end
         r = $urandom_range(0, 1) ? 0 : int'($urandom_range(0, 5));
      end else begin
         case ($urandom_range(0, 2))
            0: hw = 0;
            1: hh = 0;
            default: begin
               hw = 0;
               hh = 0;
            end
         endcase
         span = hw + hh + r + 4;
         cx   = dx + int'($urandom_range(0, 2 * span)) - span;
         cy   = dy + int'($urandom_range(0, 2 * span)) - span;
      end
      return query_of(cx, cy, r, dx, dy, hw, hh);
   endfunction

   // Gap before the next request: mostly none, some short, a few long, and
   // now and then a back-to-back burst with no gaps at all.
   function automatic int pick_gap();
      int roll;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
         burst_left = $urandom_range(50, 100);
         return 0;
      end
      if (roll < 60) return 0;
      if (roll < 90) return int'($urandom_range(1, 3));
      if (roll < 98) return int'($urandom_range(4, 10));
      return int'($urandom_range(20, 60));
   endfunction

   // Present one request at the falling edge and hold it until it is taken.
   // Returns at the falling edge right after the accepting rising edge.
   task automatic send_query(input overlap_query_t q);
      int seen_count;
      start             <= 1'b1;
      req_circle_x      <= q.circle_x;
      req_circle_y      <= q.circle_y;
      req_circle_radius <= q.circle_radius;
      req_diamond_x     <= q.diamond_x;
      req_diamond_y     <= q.diamond_y;
      req_half_width    <= q.half_width;
      req_half_height   <= q.half_height;
      seen_count = accepted_count;
      do @(negedge clock); while (accepted_count == seen_count);
   endtask

   // Drop start for a number of cycles, with junk on the request fields.
   task automatic idle_for(input int cycles);
      overlap_query_t junk;
      junk = random_query();
      start             <= 1'b0;
      req_circle_x      <= junk.circle_x;
      req_circle_y      <= junk.circle_y;
      req_circle_radius <= junk.circle_radius;
      req_diamond_x     <= junk.diamond_x;
      req_diamond_y     <= junk.diamond_y;
      req_half_width    <= junk.half_width;
      req_half_height   <= junk.half_height;
      repeat (cycles) @(negedge clock);
   endtask

   // Hold off new requests until every pending response has come back.
   task automatic drain_responses();
      start <= 1'b0;
      do @(negedge clock); while (hit_board.pending() != 0);
   endtask

   initial begin : stimulus
      int gap;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // field extremes
      send_query(query_of(0, 0, 0, 0, 0, 0, 0));
      send_query(query_of(-2048, -2048, 0, -2048, -2048, 0, 0));
      send_query(query_of(2047, 2047, 1023, 2047, 2047, 1023, 1023));
      send_query(query_of(-2048, -2048, 1023, 2047, 2047, 1023, 1023));
      send_query(query_of(2047, -2048, 1023, -2048, 2047, 1023, 1023));
      send_query(query_of(2047, 2047, 1023, -2048, -2048, 1023, 1023));
      send_query(query_of(-2048, 2047, 1, 2047, -2048, 5, 5));
      // zero radius: on an edge interior hits, on a vertex or the center not
      send_query(query_of(2, 1, 0, 0, 0, 4, 2));
      send_query(query_of(4, 0, 0, 0, 0, 4, 2));
      send_query(query_of(0, 0, 0, 0, 0, 4, 2));
      // degenerate diamond: a point, then segments along each axis
      send_query(query_of(5, 5, 0, 5, 5, 0, 0));
      send_query(query_of(5, 5, 1, 5, 5, 0, 0));
      send_query(query_of(0, 3, 0, 0, 0, 0, 7));
      send_query(query_of(3, 0, 0, 0, 0, 7, 0));
      // edge exactly tangent, then one short of it
      send_query(query_of(4, 5, 4, 0, 0, 4, 3));
      send_query(query_of(4, 5, 3, 0, 0, 4, 3));
      // vertex on the circle, then just inside
      send_query(query_of(13, 4, 5, 0, 0, 10, 10));
      send_query(query_of(13, 4, 6, 0, 0, 10, 10));
      // circle swallows the diamond; small circle deep inside a big diamond
      send_query(query_of(0, 0, 1023, 0, 0, 10, 10));
      send_query(query_of(0, 0, 3, 0, 0, 1000, 1000));
      send_query(query_of(-1, -1, 1, 0, 0, 1, 1));
      drain_responses();

      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         send_query(random_query());
         if (i % DRAIN_EVERY == DRAIN_EVERY - 1) begin
            drain_responses();
         end else begin
            gap = pick_gap();
            if (gap > 0) idle_for(gap);
         end
      end

      // flush the pipeline, then give it a few more cycles to show strays
      drain_responses();
      repeat (PIPE_DEPTH + 4) @(negedge clock);
      if (hit_board.errors == 0 && hit_board.pending() == 0) begin
         $display("** diamond_circle_overlap: PASSED **");
      end else begin
         $display("** diamond_circle_overlap: FAILED **");
      end
      $finish;
   end

endmodule
